// ----- rtl/lud_pkg.sv -----
`default_nettype none

package lud_pkg;

	// Matrix geometry: MAX_N rows of MAX_N coefficients plus the right-hand side.
	localparam int MAX_N = 8;
	localparam int STRIDE = MAX_N + 1;
	localparam int DEPTH = MAX_N * STRIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(MAX_N + 1);
	localparam int ROW_W = $clog2(MAX_N);

	// Fixed field widths of the block's ports.
	localparam int Q_W = 32;
	localparam int SIZE_W = 4;
	localparam int IDX_W = 3;

	// Source of the data written into the matrix store.
	typedef enum logic [2:0] {
		WS_COEF,
		WS_RES,
		WS_QUO,
		WS_RDATA,
		WS_OPA
	} wsel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              mem_we;
		wsel_t             wsel;
		logic [ADDR_W-1:0] waddr;
		logic [ADDR_W-1:0] raddr;
		logic              ld_base;
		logic              ld_opa;
		logic              mul_en;
		logic              acc_clr;
		logic              acc_add;
		logic              fin;
		logic              div_start;
		logic              emit;
		logic              emit_sing;
		logic [IDX_W-1:0]  emit_idx;
		logic              emit_last;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic res_nz;
		logic div_idle;
	} dp_stat_t;

	// Word address of element (row, col) in the row-major store.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [CNT_W-1:0] row,
			input logic [CNT_W-1:0] col);
		return ADDR_W'(int'(row[ROW_W-1:0]) * STRIDE + int'(col));
	endfunction

endpackage

`default_nettype wire

// ----- rtl/lud_dp.sv -----
`default_nettype none

module lud_dp (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire lud_pkg::dp_cmd_t      cmd,
	input  wire  [lud_pkg::Q_W-1:0]    coefficient,
	output lud_pkg::dp_stat_t          stat,
	output logic                       result_valid,
	output logic [lud_pkg::Q_W-1:0]    solution_value,
	output logic [lud_pkg::IDX_W-1:0]  unknown_index,
	output logic                       status,
	output logic                       last_result
);
	import lud_pkg::*;

	localparam int ACC_W = Q_W + $clog2(MAX_N);
	localparam int DIFF_W = ACC_W + 1;
	localparam int DVD_W = Q_W + 16;
	localparam int DCNT_W = $clog2(DVD_W + 1);
	localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	logic [Q_W-1:0]        mem [DEPTH];
	logic [Q_W-1:0]        rdata_q;
	logic [Q_W-1:0]        wdata;
	logic [Q_W-1:0]        base_q;
	logic [Q_W-1:0]        opa_q;
	logic [2*Q_W-1:0]      product_s1;
	logic [ACC_W-1:0]      acc_q;
	logic [Q_W-1:0]        res_q;
	logic [2*Q_W-1:0]      pmag;
	logic [DVD_W-1:0]      prnd;
	logic [Q_W-1:0]        prod_q;
	logic [DIFF_W-1:0]     diff;
	logic [Q_W-1:0]        diff_sat;
	logic [DVD_W-1:0]      dvd_q;
	logic [Q_W-1:0]        rem_q;
	logic [Q_W-1:0]        den_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic                  div_busy_q;
	logic                  div_neg_q;
	logic                  div_dz_q;
	logic                  div_nz_q;
	logic [Q_W:0]          trial;
	logic                  trial_ge;
	logic [Q_W-1:0]        quo;
	logic [Q_W-1:0]        num_mag;
	logic [Q_W-1:0]        den_mag;

	// Saturating conversion of a magnitude and a sign to a Q16.16 word.
	function automatic logic [Q_W-1:0] from_mag(input logic neg, input logic [DVD_W-1:0] q);
		if (!neg) begin
			return (q > DVD_W'(Q_MAX)) ? Q_MAX : q[Q_W-1:0];
		end
		if (q >= DVD_W'(Q_MIN)) begin
			return Q_MIN;
		end
		return Q_W'(0) - q[Q_W-1:0];
	endfunction

	// Write data selection.
	always_comb begin
		case (cmd.wsel)
			WS_COEF:  wdata = coefficient;
			WS_RES:   wdata = res_q;
			WS_QUO:   wdata = quo;
			WS_RDATA: wdata = rdata_q;
			WS_OPA:   wdata = opa_q;
			default:  wdata = res_q;
		endcase
	end

	// Matrix store with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[cmd.waddr] <= wdata;
		end
		rdata_q <= mem[cmd.raddr];
	end

	// Rounded product: magnitude, add half an LSB, drop 16 fraction bits, saturate.
	always_comb begin
		pmag = product_s1[2*Q_W-1] ? ((2*Q_W)'(0) - product_s1) : product_s1;
		prnd = DVD_W'((pmag + (2*Q_W)'(32768)) >> 16);
		prod_q = from_mag(product_s1[2*Q_W-1], prnd);
	end

	// Element minus accumulated dot sum, saturated to 32 bits.
	always_comb begin
		diff = {{(DIFF_W-Q_W){base_q[Q_W-1]}}, base_q} - {acc_q[ACC_W-1], acc_q};
		if (!diff[DIFF_W-1] && (|diff[DIFF_W-2:Q_W-1])) begin
			diff_sat = Q_MAX;
		end else if (diff[DIFF_W-1] && !(&diff[DIFF_W-2:Q_W-1])) begin
			diff_sat = Q_MIN;
		end else begin
			diff_sat = diff[Q_W-1:0];
		end
	end

	// Operand registers, multiplier stage and accumulator.
	always_ff @(posedge clk) begin
		if (cmd.ld_base) begin
			base_q <= rdata_q;
		end
		if (cmd.ld_opa) begin
			opa_q <= rdata_q;
		end
		if (cmd.mul_en) begin
			product_s1 <= 64'($signed(opa_q) * $signed(rdata_q));
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + {{(ACC_W-Q_W){prod_q[Q_W-1]}}, prod_q};
		end
		if (cmd.fin) begin
			res_q <= diff_sat;
		end
	end

	// Restoring divider: one quotient bit per cycle.
	always_comb begin
		num_mag = res_q[Q_W-1] ? (Q_W'(0) - res_q) : res_q;
		den_mag = rdata_q[Q_W-1] ? (Q_W'(0) - rdata_q) : rdata_q;
		trial = {rem_q, dvd_q[DVD_W-1]};
		trial_ge = (trial >= {1'b0, den_q});
		if (div_dz_q) begin
			quo = div_nz_q ? (div_neg_q ? Q_MIN : Q_MAX) : '0;
		end else begin
			quo = from_mag(div_neg_q, dvd_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
		end else if (cmd.div_start) begin
			div_busy_q <= (den_mag != '0);
		end else if (div_busy_q && dcnt_q == DCNT_W'(1)) begin
			div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= {num_mag, 16'h0000} + DVD_W'(den_mag[Q_W-1:1]);
			den_q <= den_mag;
			rem_q <= '0;
			dcnt_q <= DCNT_W'(DVD_W);
			div_dz_q <= (den_mag == '0);
			div_nz_q <= (res_q != '0);
			div_neg_q <= (den_mag == '0) ? res_q[Q_W-1] : (res_q[Q_W-1] ^ rdata_q[Q_W-1]);
		end else if (div_busy_q) begin
			rem_q <= trial_ge ? Q_W'(trial - {1'b0, den_q}) : trial[Q_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], trial_ge};
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	// Result registers; the strobe lasts exactly one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit || cmd.emit_sing;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sing) begin
			solution_value <= '0;
			unknown_index <= '0;
			status <= 1'b1;
			last_result <= 1'b1;
		end else if (cmd.emit) begin
			solution_value <= rdata_q;
			unknown_index <= cmd.emit_idx;
			status <= 1'b0;
			last_result <= cmd.emit_last;
		end
	end

	assign stat.res_nz = (res_q != '0);
	assign stat.div_idle = !div_busy_q;

endmodule

`default_nettype wire

// ----- rtl/lud_ctrl.sv -----
`default_nettype none

module lud_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire                         cfg_we,
	input  wire  [lud_pkg::SIZE_W-1:0]  cfg_wdata,
	input  wire lud_pkg::dp_stat_t      stat,
	output logic                        busy,
	output lud_pkg::dp_cmd_t            cmd
);
	import lud_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE   = 19'h00001,
		S_RBASE  = 19'h00002,
		S_BASE   = 19'h00004,
		S_TA     = 19'h00008,
		S_TB     = 19'h00010,
		S_MUL    = 19'h00020,
		S_ACC    = 19'h00040,
		S_FIN    = 19'h00080,
		S_DECIDE = 19'h00100,
		S_RDIV   = 19'h00200,
		S_DIVGO  = 19'h00400,
		S_DIVW   = 19'h00800,
		S_SWRA   = 19'h01000,
		S_SWRB   = 19'h02000,
		S_SWWA   = 19'h04000,
		S_SWWB   = 19'h08000,
		S_ORD    = 19'h10000,
		S_OUT    = 19'h20000,
		S_SING   = 19'h40000
	} state_t;

	// What the current dot-sum reduction is for.
	typedef enum logic [2:0] {
		C_PIV,
		C_UROW,
		C_LCOL,
		C_FWD,
		C_BACK
	} ctx_t;

	localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

	state_t             state_q;
	ctx_t               ctx_q;
	logic [SIZE_W-1:0]  size_q;
	logic [CNT_W-1:0]   n;
	logic [CNT_W-1:0]   lrow_q, lcol_q;
	logic [CNT_W-1:0]   k_q, i_q, j_q, pr_q;
	logic [CNT_W-1:0]   r_q, c_q, h_q, hi_q;

	// Effective system size, clamped to 1..MAX_N.
	always_comb begin
		if (size_q == '0) begin
			n = ONE;
		end else if (int'(size_q) > MAX_N) begin
			n = CNT_W'(MAX_N);
		end else begin
			n = CNT_W'(size_q);
		end
	end

	assign busy = (state_q != S_IDLE);

	// Sequencer: loading, pivoting, factorization, substitution and readout.
	always_ff @(posedge clk or negedge arst_n) begin
		logic             go, do_nextk, do_fwd, do_back;
		logic [CNT_W-1:0] gr, gc, glo, ghi;
		if (!arst_n) begin
			state_q <= S_IDLE;
			ctx_q <= C_PIV;
			size_q <= SIZE_W'(MAX_N);
			lrow_q <= '0;
			lcol_q <= '0;
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
			pr_q <= '0;
			r_q <= '0;
			c_q <= '0;
			h_q <= '0;
			hi_q <= '0;
		end else begin
			go = 1'b0;
			do_nextk = 1'b0;
			do_fwd = 1'b0;
			do_back = 1'b0;
			gr = '0;
			gc = '0;
			glo = '0;
			ghi = '0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (lcol_q == n) begin
							lcol_q <= '0;
							if (lrow_q + ONE == n) begin
								lrow_q <= '0;
								k_q <= '0;
								i_q <= '0;
								ctx_q <= C_PIV;
								go = 1'b1;
							end else begin
								lrow_q <= lrow_q + ONE;
							end
						end else begin
							lcol_q <= lcol_q + ONE;
						end
					end
				end
				S_RBASE: state_q <= S_BASE;
				S_BASE:  state_q <= (h_q < hi_q) ? S_TA : S_FIN;
				S_TA:    state_q <= S_TB;
				S_TB:    state_q <= S_MUL;
				S_MUL:   state_q <= S_ACC;
				S_ACC: begin
					h_q <= h_q + ONE;
					state_q <= (h_q + ONE < hi_q) ? S_TA : S_FIN;
				end
				S_FIN: state_q <= S_DECIDE;
				S_DECIDE: begin
					unique case (ctx_q)
						C_PIV: begin
							if (stat.res_nz) begin
								pr_q <= i_q;
								if (i_q != k_q) begin
									j_q <= '0;
									state_q <= S_SWRA;
								end else begin
									ctx_q <= C_UROW;
									j_q <= k_q;
									go = 1'b1;
									gr = k_q;
									gc = k_q;
									ghi = k_q;
								end
							end else if (i_q + ONE == n) begin
								state_q <= S_SING;
							end else begin
								i_q <= i_q + ONE;
								go = 1'b1;
								gr = i_q + ONE;
								gc = k_q;
								ghi = k_q;
							end
						end
						C_UROW: begin
							if (j_q + ONE < n) begin
								j_q <= j_q + ONE;
								go = 1'b1;
								gr = k_q;
								gc = j_q + ONE;
								ghi = k_q;
							end else if (k_q + ONE < n) begin
								ctx_q <= C_LCOL;
								i_q <= k_q + ONE;
								go = 1'b1;
								gr = k_q + ONE;
								gc = k_q;
								ghi = k_q;
							end else begin
								do_nextk = 1'b1;
							end
						end
						C_FWD: begin
							if (i_q + ONE < n) begin
								i_q <= i_q + ONE;
								go = 1'b1;
								gr = i_q + ONE;
								gc = n;
								ghi = i_q + ONE;
							end else begin
								do_back = 1'b1;
							end
						end
						C_LCOL, C_BACK: state_q <= S_RDIV;
						default: state_q <= S_IDLE;
					endcase
				end
				S_RDIV:  state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DIVW;
				S_DIVW: begin
					if (stat.div_idle) begin
						if (ctx_q == C_LCOL) begin
							if (i_q + ONE < n) begin
								i_q <= i_q + ONE;
								go = 1'b1;
								gr = i_q + ONE;
								gc = k_q;
								ghi = k_q;
							end else begin
								do_nextk = 1'b1;
							end
						end else if (i_q == '0) begin
							state_q <= S_ORD;
						end else begin
							i_q <= i_q - ONE;
							go = 1'b1;
							gr = i_q - ONE;
							gc = n;
							glo = i_q;
							ghi = n;
						end
					end
				end
				S_SWRA: state_q <= S_SWRB;
				S_SWRB: state_q <= S_SWWA;
				S_SWWA: state_q <= S_SWWB;
				S_SWWB: begin
					if (j_q == n) begin
						ctx_q <= C_UROW;
						j_q <= k_q;
						go = 1'b1;
						gr = k_q;
						gc = k_q;
						ghi = k_q;
					end else begin
						j_q <= j_q + ONE;
						state_q <= S_SWRA;
					end
				end
				S_ORD: state_q <= S_OUT;
				S_OUT: begin
					if (i_q + ONE == n) begin
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + ONE;
						state_q <= S_ORD;
					end
				end
				S_SING: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase

			// Advance to the next pivot column, or on to substitution.
			if (do_nextk) begin
				if (k_q + ONE < n) begin
					ctx_q <= C_PIV;
					k_q <= k_q + ONE;
					i_q <= k_q + ONE;
					go = 1'b1;
					gr = k_q + ONE;
					gc = k_q + ONE;
					glo = '0;
					ghi = k_q + ONE;
				end else begin
					do_fwd = 1'b1;
				end
			end
			if (do_fwd) begin
				if (n > ONE) begin
					ctx_q <= C_FWD;
					i_q <= ONE;
					go = 1'b1;
					gr = ONE;
					gc = n;
					glo = '0;
					ghi = ONE;
				end else begin
					do_back = 1'b1;
				end
			end
			if (do_back) begin
				ctx_q <= C_BACK;
				i_q <= n - ONE;
				go = 1'b1;
				gr = n - ONE;
				gc = n;
				glo = n;
				ghi = n;
			end

			// Launch a reduction: element (r, c) minus sum over h in [lo, hi).
			if (go) begin
				r_q <= gr;
				c_q <= gc;
				h_q <= glo;
				hi_q <= ghi;
				state_q <= S_RBASE;
			end

			// A size write restarts loading.
			if (cfg_we) begin
				size_q <= cfg_wdata;
				lrow_q <= '0;
				lcol_q <= '0;
			end
		end
	end

	// Datapath commands decoded from the state.
	always_comb begin
		cmd = '0;
		cmd.wsel = WS_RES;
		unique case (state_q)
			S_IDLE: begin
				cmd.mem_we = start;
				cmd.wsel = WS_COEF;
				cmd.waddr = cell_addr(lrow_q, lcol_q);
			end
			S_RBASE: begin
				cmd.raddr = cell_addr(r_q, c_q);
				cmd.acc_clr = 1'b1;
			end
			S_BASE: cmd.ld_base = 1'b1;
			S_TA:   cmd.raddr = cell_addr(r_q, h_q);
			S_TB: begin
				cmd.ld_opa = 1'b1;
				cmd.raddr = cell_addr(h_q, c_q);
			end
			S_MUL: cmd.mul_en = 1'b1;
			S_ACC: cmd.acc_add = 1'b1;
			S_FIN: cmd.fin = 1'b1;
			S_DECIDE: begin
				if (ctx_q == C_UROW) begin
					cmd.mem_we = 1'b1;
					cmd.waddr = cell_addr(k_q, j_q);
				end else if (ctx_q == C_FWD) begin
					cmd.mem_we = 1'b1;
					cmd.waddr = cell_addr(i_q, n);
				end
			end
			S_RDIV: begin
				cmd.raddr = (ctx_q == C_LCOL) ? cell_addr(k_q, k_q) : cell_addr(i_q, i_q);
			end
			S_DIVGO: cmd.div_start = 1'b1;
			S_DIVW: begin
				cmd.mem_we = stat.div_idle;
				cmd.wsel = WS_QUO;
				cmd.waddr = (ctx_q == C_LCOL) ? cell_addr(i_q, k_q) : cell_addr(i_q, n);
			end
			S_SWRA: cmd.raddr = cell_addr(k_q, j_q);
			S_SWRB: begin
				cmd.ld_opa = 1'b1;
				cmd.raddr = cell_addr(pr_q, j_q);
			end
			S_SWWA: begin
				cmd.mem_we = 1'b1;
				cmd.wsel = WS_RDATA;
				cmd.waddr = cell_addr(k_q, j_q);
			end
			S_SWWB: begin
				cmd.mem_we = 1'b1;
				cmd.wsel = WS_OPA;
				cmd.waddr = cell_addr(pr_q, j_q);
			end
			S_ORD: cmd.raddr = cell_addr(i_q, n);
			S_OUT: begin
				cmd.emit = 1'b1;
				cmd.emit_idx = i_q[IDX_W-1:0];
				cmd.emit_last = (i_q + ONE == n);
			end
			S_SING: cmd.emit_sing = 1'b1;
			default: cmd.wsel = WS_RES;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/lu_doolittle_linear_solver.sv -----
`default_nettype none

// Doolittle LU solver for an n by n system in signed Q16.16. Coefficients of the
// augmented matrix [A | b] are taken row by row, n+1 per row, one per cycle whenever
// start is high and busy is low. The transaction that delivers the last element
// starts the solve: busy then stays high while the matrix is factored with row
// pivoting and forward and back substitution run. Every step goes through the single
// read port of the matrix store, and each division runs on the 48-step bit-serial
// divider. Each row swap lengthens the solve, and each rejected pivot row adds one
// more reduction. The n solutions follow, each on the result ports for one cycle
// with result_valid high; the receiver cannot stall them. A singular system gives
// one result with status set instead. Write cfg_we/cfg_wdata only while idle;
// it restarts loading.
module lu_doolittle_linear_solver (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire  [lud_pkg::Q_W-1:0]     coefficient,
	input  wire                         cfg_we,
	input  wire  [lud_pkg::SIZE_W-1:0]  cfg_wdata,
	output logic                        result_valid,
	output logic [lud_pkg::Q_W-1:0]     solution_value,
	output logic [lud_pkg::IDX_W-1:0]   unknown_index,
	output logic                        status,
	output logic                        last_result
);
	import lud_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lud_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.busy      (busy),
		.cmd       (cmd)
	);

	lud_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.coefficient    (coefficient),
		.stat           (stat),
		.result_valid   (result_valid),
		.solution_value (solution_value),
		.unknown_index  (unknown_index),
		.status         (status),
		.last_result    (last_result)
	);

`ifndef ASSERT_OFF
	// A singular status is always the only, and so the last, result of a run.
	a_sing_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> last_result && solution_value == '0)
		else $error("singular result not marked last or not zero");

	// More results are still to come, so the block cannot be idle.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |-> busy)
		else $error("block idle while results are still pending");

	// Solutions leave in index order.
	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |=> ##1 result_valid &&
			unknown_index == $past(unknown_index, 2) + 3'd1)
		else $error("solution index out of order");
`endif

endmodule

`default_nettype wire
